[src/ecse_pkg.sv]
// ecse_pkg: shared types and constants for the encoder count speed estimator
// used by every module of the block; no dependencies

package ecse_pkg;

   // event kinds as they arrive on the request channel
   localparam logic [1:0] KIND_UP    = 2'd0;
   localparam logic [1:0] KIND_DOWN  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;
   localparam logic [1:0] KIND_READ  = 2'd3;

   // speed arithmetic constants
   localparam logic [31:0] SPEED_SCALE = 32'd1000000;
   localparam logic [3:0]  DECAY_TOP   = 4'd11;
   localparam logic [31:0] DECAY_DIV   = 32'd10;
   localparam logic [3:0]  STALE_MAX   = 4'd10;
   localparam logic [31:0] SPEED_SAT   = 32'hFFFF_FFFF;

   // iterative divider: one quotient bit a cycle
   localparam int DIV_STEPS = 32;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // command queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // register file
   localparam int          CSR_AW      = 3;
   localparam logic        CSR_DPC_IDX = 1'b0;
   localparam logic [31:0] DPC_RESET   = 32'h0001_0000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] time_us;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] count;
      logic [31:0]        speed;
   } rsp_item_type;

   // classified command as queued for the back end
   typedef struct packed {
      logic [1:0]  op;
      logic        stamped;
      logic [31:0] stamp;
   } cmd_type;

endpackage

[src/encoder_count_speed_estimator.sv]
// encoder_count_speed_estimator: top level, register port and front/back wiring
// depends on ecse_pkg, ecse_front, ecse_fifo, ecse_back
//
//   channel   | ports                         | transfer when
//   ----------+-------------------------------+------------------------------------
//   request   | req_push, req_full, req_item  | req_push && !req_full
//   response  | rsp_empty, rsp_pop, rsp_item  | rsp_pop && !rsp_empty
//   register  | csr_psel .. csr_pready        | psel && penable && pwrite && pready
//
// count up, count down and clear are done in the back end's idle state; a fresh
// speed read runs through operand setup, one 32x32 product, two 32x20 scale
// products, an add, an overflow check, 32 divider steps and a result load; a
// decaying read skips the scale products and the add, a fully decayed read goes
// from setup straight to the result load. reset is synchronous and clears the
// control state; dpc resets to 1.0. the front keeps taking requests into a
// 4-deep queue while the back end works or waits on a full response register.

module encoder_count_speed_estimator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  ecse_pkg::req_item_type        req_item,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output ecse_pkg::rsp_item_type        rsp_item,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [ecse_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   logic [31:0]       dpc_ff, dpc_in;
   logic              csr_wr;
   logic              fifo_wr, fifo_full, fifo_rd, fifo_empty;
   ecse_pkg::cmd_type fifo_wdata, fifo_rdata;

   // distance per count register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == ecse_pkg::CSR_DPC_IDX);
   assign dpc_in     = csr_wr ? csr_pwdata : dpc_ff;
   assign csr_prdata = (csr_paddr[2] == ecse_pkg::CSR_DPC_IDX) ? dpc_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dpc_ff <= ecse_pkg::DPC_RESET;
      end else begin
         dpc_ff <= dpc_in;
      end
   end

   // front end
   ecse_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .fifo_full (fifo_full),
      .fifo_wr   (fifo_wr),
      .fifo_data (fifo_wdata)
   );

   // command queue
   ecse_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fifo_wr),
      .wr_data (fifo_wdata),
      .full    (fifo_full),
      .rd_en   (fifo_rd),
      .rd_data (fifo_rdata),
      .empty   (fifo_empty)
   );

   // back end
   ecse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .dpc       (dpc_ff),
      .cmd_valid (!fifo_empty),
      .cmd       (fifo_rdata),
      .cmd_pop   (fifo_rd),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule

[src/ecse_fifo.sv]
// ecse_fifo: small first-word fall-through command queue
// depends on ecse_pkg for the command type and depth

module ecse_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  ecse_pkg::cmd_type wr_data,
   output logic             full,
   input  logic             rd_en,
   output ecse_pkg::cmd_type rd_data,
   output logic             empty
);

   ecse_pkg::cmd_type              slot_ff [ecse_pkg::FIFO_DEPTH];
   logic [ecse_pkg::FIFO_AW-1:0]   wptr_ff, wptr_in;
   logic [ecse_pkg::FIFO_AW-1:0]   rptr_ff, rptr_in;
   logic [ecse_pkg::FIFO_AW:0]     fill_ff, fill_in;
   logic                           do_wr, do_rd;

   assign full    = (fill_ff == (ecse_pkg::FIFO_AW+1)'(ecse_pkg::FIFO_DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wptr_in = do_wr ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_rd ? rptr_ff + 1'b1 : rptr_ff;
      fill_in = fill_ff;
      if (do_wr && !do_rd) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wptr_ff] <= wr_data;
      end
   end

endmodule

[src/ecse_front.sv]
// ecse_front: accepts request transfers, classifies them into commands
// depends on ecse_pkg; feeds ecse_fifo

module ecse_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  ecse_pkg::req_item_type req_item,
   input  logic                   fifo_full,
   output logic                   fifo_wr,
   output ecse_pkg::cmd_type      fifo_data
);

   logic              stage_valid_ff, stage_valid_in;
   ecse_pkg::cmd_type stage_ff, stage_in;
   ecse_pkg::cmd_type decoded;
   logic              take, drain;

   // classify: only count events carry a time stamp
   always_comb begin
      decoded.op = req_item.kind;
      unique case (req_item.kind)
         ecse_pkg::KIND_UP, ecse_pkg::KIND_DOWN: begin
            decoded.stamped = 1'b1;
            decoded.stamp   = req_item.time_us;
         end
         ecse_pkg::KIND_CLEAR, ecse_pkg::KIND_READ: begin
            decoded.stamped = 1'b0;
            decoded.stamp   = '0;
         end
         default: begin
            decoded.stamped = 1'b0;
            decoded.stamp   = '0;
         end
      endcase
   end

   // single holding stage in front of the queue
   assign drain     = stage_valid_ff && !fifo_full;
   assign req_full  = stage_valid_ff && fifo_full;
   assign take      = req_push && !req_full;
   assign fifo_wr   = drain;
   assign fifo_data = stage_ff;

   always_comb begin
      stage_valid_in = take || (stage_valid_ff && !drain);
      stage_in       = take ? decoded : stage_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

endmodule

[src/ecse_back.sv]
// ecse_back: executes queued commands; count state, speed estimate and decay
// depends on ecse_pkg; shared 32x32 multiplier and bit-serial divider

module ecse_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [31:0]            dpc,
   input  logic                   cmd_valid,
   input  ecse_pkg::cmd_type      cmd,
   output logic                   cmd_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output ecse_pkg::rsp_item_type rsp_item
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PROD = 3'd1;
   localparam logic [2:0] ST_MLO  = 3'd2;
   localparam logic [2:0] ST_MHI  = 3'd3;
   localparam logic [2:0] ST_SUM  = 3'd4;
   localparam logic [2:0] ST_CHK  = 3'd5;
   localparam logic [2:0] ST_DIV  = 3'd6;
   localparam logic [2:0] ST_PUT  = 3'd7;

   localparam int STEP_LOCAL = ecse_pkg::STEP_W;

   logic [2:0]  state_ff, state_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] cae_ff, cae_in;
   logic [31:0] last_ff, last_in;
   logic [31:0] tae_ff, tae_in;
   logic [31:0] held_ff, held_in;
   logic [3:0]  stale_ff, stale_in;
   logic        fresh_ff, fresh_in;
   logic [31:0] opa_ff, opa_in;
   logic [31:0] opb_ff, opb_in;
   logic [31:0] div_ff, div_in;
   logic [63:0] p_ff, p_in;
   logic [51:0] pl_ff, pl_in;
   logic [51:0] nh_ff, nh_in;
   logic [31:0] nl_ff, nl_in;
   logic [31:0] rem_ff, rem_in;
   logic [STEP_LOCAL-1:0] step_ff, step_in;
   logic [31:0] res_ff, res_in;
   logic        out_valid_ff, out_valid_in;
   ecse_pkg::rsp_item_type out_ff, out_in;

   logic [31:0] delta, mag;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_out;
   logic [32:0] trial;
   logic [33:0] diff;
   logic        ge;
   logic        out_free;

   // shared multiplier operand select
   always_comb begin
      unique case (state_ff)
         ST_MLO: begin
            mul_a = p_ff[31:0];
            mul_b = ecse_pkg::SPEED_SCALE;
         end
         ST_MHI: begin
            mul_a = p_ff[63:32];
            mul_b = ecse_pkg::SPEED_SCALE;
         end
         ST_IDLE, ST_PROD, ST_SUM, ST_CHK, ST_DIV, ST_PUT: begin
            mul_a = opa_ff;
            mul_b = opb_ff;
         end
         default: begin
            mul_a = opa_ff;
            mul_b = opb_ff;
         end
      endcase
   end

   assign mul_out = {32'b0, mul_a} * {32'b0, mul_b};

   // count change magnitude since the last estimate
   assign delta = pos_ff - cae_ff;
   assign mag   = delta[31] ? (32'd0 - delta) : delta;

   // one restoring division step
   assign trial = {rem_ff, nl_ff[31]};
   assign diff  = {1'b0, trial} - {2'b0, div_ff};
   assign ge    = !diff[33];

   assign out_free  = !out_valid_ff || rsp_pop;
   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      cae_in       = cae_ff;
      last_in      = last_ff;
      tae_in       = tae_ff;
      held_in      = held_ff;
      stale_in     = stale_ff;
      fresh_in     = fresh_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      div_in       = div_ff;
      p_in         = p_ff;
      pl_in        = pl_ff;
      nh_in        = nh_ff;
      nl_in        = nl_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      cmd_pop      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  ecse_pkg::KIND_UP: begin
                     pos_in  = pos_ff + 32'd1;
                     last_in = cmd.stamp;
                  end
                  ecse_pkg::KIND_DOWN: begin
                     pos_in  = pos_ff - 32'd1;
                     last_in = cmd.stamp;
                  end
                  ecse_pkg::KIND_CLEAR: begin
                     pos_in = '0;
                  end
                  default: begin
                     if (last_ff != tae_ff) begin
                        // fresh estimate
                        opa_in   = mag;
                        opb_in   = dpc;
                        div_in   = last_ff - tae_ff;
                        cae_in   = pos_ff;
                        tae_in   = last_ff;
                        stale_in = 4'd1;
                        fresh_in = 1'b1;
                        state_in = ST_PROD;
                     end else if (stale_ff > ecse_pkg::STALE_MAX) begin
                        // fully decayed
                        res_in   = '0;
                        fresh_in = 1'b0;
                        state_in = ST_PUT;
                     end else begin
                        // linear decay of the held speed
                        opa_in   = held_ff;
                        opb_in   = {28'b0, ecse_pkg::DECAY_TOP - stale_ff};
                        div_in   = ecse_pkg::DECAY_DIV;
                        stale_in = stale_ff + 4'd1;
                        fresh_in = 1'b0;
                        state_in = ST_PROD;
                     end
                  end
               endcase
            end
         end
         ST_PROD: begin
            p_in = mul_out;
            if (fresh_ff) begin
               state_in = ST_MLO;
            end else begin
               nh_in    = {20'b0, mul_out[63:32]};
               nl_in    = mul_out[31:0];
               state_in = ST_CHK;
            end
         end
         ST_MLO: begin
            pl_in    = mul_out[51:0];
            state_in = ST_MHI;
         end
         ST_MHI: begin
            nh_in    = mul_out[51:0];
            state_in = ST_SUM;
         end
         ST_SUM: begin
            nh_in    = nh_ff + {32'b0, pl_ff[51:32]};
            nl_in    = pl_ff[31:0];
            state_in = ST_CHK;
         end
         ST_CHK: begin
            // quotient fits 32 bits only if the upper part is below the divisor
            if (nh_ff >= {20'b0, div_ff}) begin
               res_in   = ecse_pkg::SPEED_SAT;
               state_in = ST_PUT;
            end else begin
               rem_in   = nh_ff[31:0];
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = ge ? diff[31:0] : trial[31:0];
            nl_in   = {nl_ff[30:0], ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LOCAL'(ecse_pkg::DIV_STEPS - 1)) begin
               res_in   = {nl_ff[30:0], ge};
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            if (out_free) begin
               out_in.count = pos_ff;
               out_in.speed = res_ff;
               out_valid_in = 1'b1;
               if (fresh_ff) begin
                  held_in = res_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         cae_ff       <= '0;
         last_ff      <= '0;
         tae_ff       <= '0;
         held_ff      <= '0;
         stale_ff     <= 4'd1;
         fresh_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         cae_ff       <= cae_in;
         last_ff      <= last_in;
         tae_ff       <= tae_in;
         held_ff      <= held_in;
         stale_ff     <= stale_in;
         fresh_ff     <= fresh_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      opa_ff  <= opa_in;
      opb_ff  <= opb_in;
      div_ff  <= div_in;
      p_ff    <= p_in;
      pl_ff   <= pl_in;
      nh_ff   <= nh_in;
      nl_ff   <= nl_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

endmodule

[src/ecse_checker.sv]
// ecse_checker: port-level checks for the encoder count speed estimator
// depends on ecse_pkg; bound to the top level below

module ecse_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_full,
   input logic                          rsp_empty,
   input logic                          rsp_pop,
   input ecse_pkg::rsp_item_type        rsp_item,
   input logic                          csr_psel,
   input logic                          csr_penable,
   input logic                          csr_pwrite,
   input logic [ecse_pkg::CSR_AW-1:0]   csr_paddr,
   input logic [31:0]                   csr_pwdata,
   input logic [31:0]                   csr_prdata,
   input logic                          csr_pready
);

   // reset leaves the block open for requests with nothing to deliver
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("block not idle after reset");

   // a waiting result is held until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_item)))
      else $error("response changed while stalled");

   // a register write reads back on the next cycle
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready
       && (csr_paddr[2] == ecse_pkg::CSR_DPC_IDX))
      |=> ((csr_paddr[2] != ecse_pkg::CSR_DPC_IDX) || (csr_prdata == $past(csr_pwdata))))
      else $error("distance per count readback mismatch");

endmodule

bind encoder_count_speed_estimator ecse_checker u_checker (.*);

[test/tb_encoder_count_speed_estimator.sv]
`timescale 1ns / 1ps
// tb_encoder_count_speed_estimator: self-checking bench for the encoder speed estimator
// drives encoder events and speed reads, predicts each read and checks it field by field
// depends on ecse_pkg and encoder_count_speed_estimator

module tb_encoder_count_speed_estimator;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 60;
   localparam int IDLE_MAX      = 17;
   localparam int PHASE_ITEMS   = 250;
   localparam logic [ecse_pkg::CSR_AW-1:0] DPC_ADDR = {ecse_pkg::CSR_DPC_IDX, 2'b00};

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_push = 1'b0;
   logic                            req_full;
   ecse_pkg::req_item_type          req_item = '0;
   logic                            rsp_empty;
   logic                            rsp_pop = 1'b0;
   ecse_pkg::rsp_item_type          rsp_item;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [ecse_pkg::CSR_AW-1:0]     csr_paddr = '0;
   logic [31:0]                     csr_pwdata = '0;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   // predicted block state
   logic [31:0]            dist_per_count;
   logic [31:0]            enc_count;
   logic [31:0]            est_count;
   logic [31:0]            evt_stamp;
   logic [31:0]            est_stamp;
   logic [31:0]            held_speed;
   logic [3:0]             stale_level;
   ecse_pkg::rsp_item_type expected_reads[$];

   int          fail_count = 0;
   int          cycle_count = 0;
   int          push_idle_max = IDLE_MAX;
   int          pop_idle_max = IDLE_MAX;
   int          pop_hold = 0;
   int          pop_stall = 0;
   logic [31:0] stamp_now = '0;

   encoder_count_speed_estimator dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_item    (req_item),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_item    (rsp_item),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** encoder_count_speed_estimator: FAILED **");
         $finish;
      end
   end

   // |count change| * distance per count * 1e6 / stamp gap, truncated and saturated
   function automatic logic [31:0] speed_from_motion(logic [31:0] mag, logic [31:0] dpc,
                                                     logic [31:0] gap);
      logic [63:0] prod;
      logic [63:0] quo;
      logic [63:0] rem;
      logic [63:0] scaled;
      prod = {32'd0, mag} * {32'd0, dpc};
      quo  = prod / {32'd0, gap};
      rem  = prod % {32'd0, gap};
      if (quo > 64'h0000_0000_FFFF_FFFF)
         return ecse_pkg::SPEED_SAT;
      scaled = quo * {32'd0, ecse_pkg::SPEED_SCALE}
               + (rem * {32'd0, ecse_pkg::SPEED_SCALE}) / {32'd0, gap};
      if (scaled > 64'h0000_0000_FFFF_FFFF)
         return ecse_pkg::SPEED_SAT;
      return scaled[31:0];
   endfunction

   // advance the predicted state by one accepted event; reads queue their result
   function automatic void apply_event(ecse_pkg::req_item_type ev);
      logic [31:0]            delta;
      logic [31:0]            mag;
      logic [31:0]            speed;
      logic [63:0]            decayed;
      ecse_pkg::rsp_item_type res;
      case (ev.kind)
         ecse_pkg::KIND_UP: begin
            enc_count = enc_count + 32'd1;
            evt_stamp = ev.time_us;
         end
         ecse_pkg::KIND_DOWN: begin
            enc_count = enc_count - 32'd1;
            evt_stamp = ev.time_us;
         end
         ecse_pkg::KIND_CLEAR: begin
            enc_count = '0;
         end
         default: begin
            if (evt_stamp != est_stamp) begin
               // fresh estimate from motion since the last one
               delta = enc_count - est_count;
               mag = delta[31] ? (32'd0 - delta) : delta;
               held_speed = speed_from_motion(mag, dist_per_count, evt_stamp - est_stamp);
               est_count = enc_count;
               est_stamp = evt_stamp;
               stale_level = 4'd1;
               speed = held_speed;
            end else if (stale_level > ecse_pkg::STALE_MAX) begin
               speed = '0;
            end else begin
               // linear decay of the held speed
               decayed = {32'd0, held_speed} * {60'd0, ecse_pkg::DECAY_TOP - stale_level}
                         / {32'd0, ecse_pkg::DECAY_DIV};
               stale_level = stale_level + 4'd1;
               speed = decayed[31:0];
            end
            res.count = enc_count;
            res.speed = speed;
            expected_reads.push_back(res);
         end
      endcase
   endfunction

   // result checker: every response transfer against the oldest prediction
   always @(posedge clock) begin : check_reads
      ecse_pkg::rsp_item_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_reads.size() == 0) begin
            $display("%0t: unexpected read result, expected none, actual count %0d speed %h",
                     $time, rsp_item.count, rsp_item.speed);
            fail_count++;
         end else begin
            want = expected_reads.pop_front();
            if (rsp_item.count !== want.count) begin
               $display("%0t: count mismatch, expected %0d actual %0d",
                        $time, want.count, rsp_item.count);
               fail_count++;
            end
            if (rsp_item.speed !== want.speed) begin
               $display("%0t: speed mismatch, expected %h actual %h",
                        $time, want.speed, rsp_item.speed);
               fail_count++;
            end
         end
         pop_stall = $urandom_range(0, pop_idle_max);
      end
   end

   // receiver: long hold-off first, then the per-result stall
   always @(negedge clock) begin
      if (pop_hold > 0) begin
         rsp_pop <= 1'b0;
         pop_hold--;
      end else if (pop_stall > 0) begin
         rsp_pop <= 1'b0;
         pop_stall--;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // one request transfer after a random gap; push stays high across back-to-back items
   task automatic push_event(input logic [1:0] ev_kind, input logic [31:0] stamp);
      int gap;
      gap = $urandom_range(0, push_idle_max);
      if (gap > 0) begin
         @(negedge clock);
         req_push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_push <= 1'b1;
      req_item <= {ev_kind, stamp};
      @(posedge clock);
      while (req_full) @(posedge clock);
      apply_event(req_item);
   endtask

   // stop sending and let every predicted read and any trailing event drain
   task automatic wait_idle();
      @(negedge clock);
      req_push <= 1'b0;
      while (expected_reads.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write with read-back, only once the block is idle
   task automatic write_distance_per_count(input logic [31:0] value);
      wait_idle();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= DPC_ADDR;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      dist_per_count = value;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== value) begin
         $display("%0t: distance_per_count read-back mismatch, expected %h actual %h",
                  $time, value, csr_prdata);
         fail_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // random motion: runs in one direction with reads, clears and some noise mixed in
   task automatic run_motion(input int n_items);
      logic [1:0]  dir;
      logic [31:0] step;
      int          roll;
      dir = ecse_pkg::KIND_UP;
      for (int i = 0; i < n_items; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            push_event(2'($urandom_range(0, 3)), $urandom);
         end else if (roll < 27) begin
            push_event(ecse_pkg::KIND_READ, $urandom);
         end else if (roll < 30) begin
            push_event(ecse_pkg::KIND_CLEAR, $urandom);
         end else begin
            if ($urandom_range(0, 9) == 0)
               dir = (dir == ecse_pkg::KIND_UP) ? ecse_pkg::KIND_DOWN : ecse_pkg::KIND_UP;
            roll = $urandom_range(0, 99);
            if (roll < 5)
               step = '0;
            else if (roll < 10)
               step = $urandom;
            else if (roll < 80)
               step = $urandom_range(1, 2000);
            else
               step = $urandom_range(2001, 5_000_000);
            stamp_now = stamp_now + step;
            push_event(dir, stamp_now);
         end
      end
   endtask

   // first read after reset, one fresh estimate, then full decay down to zero
   task automatic test_estimate_and_decay();
      push_event(ecse_pkg::KIND_READ, 32'd0);
      push_event(ecse_pkg::KIND_UP, 32'd1000);
      push_event(ecse_pkg::KIND_UP, 32'd2000);
      push_event(ecse_pkg::KIND_READ, 32'd0);
      repeat (11) push_event(ecse_pkg::KIND_READ, 32'hFFFF_FFFF);
   endtask

   // stamp wrap, saturation, clear jump, repeated stamp, zero distance
   task automatic test_wrap_and_saturation();
      push_event(ecse_pkg::KIND_DOWN, 32'hFFFF_FFFF);
      push_event(ecse_pkg::KIND_READ, 32'd0);
      push_event(ecse_pkg::KIND_UP, 32'h0000_0000);
      push_event(ecse_pkg::KIND_READ, 32'd0);
      push_event(ecse_pkg::KIND_CLEAR, 32'h5555_5555);
      push_event(ecse_pkg::KIND_READ, 32'd0);
      push_event(ecse_pkg::KIND_UP, 32'h0000_0000);
      push_event(ecse_pkg::KIND_READ, 32'd0);
      write_distance_per_count(32'hFFFF_FFFF);
      push_event(ecse_pkg::KIND_UP, 32'd1);
      push_event(ecse_pkg::KIND_READ, 32'd0);
      write_distance_per_count(32'd0);
      push_event(ecse_pkg::KIND_DOWN, 32'd500);
      push_event(ecse_pkg::KIND_READ, 32'd0);
      stamp_now = 32'd500;
   endtask

   // random phases across distance settings and idle patterns
   task automatic test_distance_settings();
      logic [31:0] settings [6];
      settings[0] = $urandom;
      settings[1] = 32'd0;
      settings[2] = 32'd1;
      settings[3] = 32'hFFFF_FFFF;
      settings[4] = ecse_pkg::DPC_RESET;
      settings[5] = $urandom_range(1, 4_000_000);
      for (int p = 0; p < 6; p++) begin
         write_distance_per_count(settings[p]);
         push_idle_max = (p == 2) ? 0 : IDLE_MAX;
         pop_idle_max  = (p == 2 || p == 4) ? 0 : IDLE_MAX;
         run_motion(PHASE_ITEMS);
      end
      push_idle_max = IDLE_MAX;
      pop_idle_max  = IDLE_MAX;
   endtask

   // receiver holds off while the sender keeps offering, then sender waits for drain
   task automatic test_backpressure();
      wait_idle();
      push_idle_max = 0;
      pop_hold = 400;
      for (int i = 0; i < 40; i++) begin
         if (i % 3 == 0) begin
            stamp_now = stamp_now + $urandom_range(1, 3000);
            push_event(ecse_pkg::KIND_UP, stamp_now);
         end else begin
            push_event(ecse_pkg::KIND_READ, $urandom);
         end
      end
      wait_idle();
      push_idle_max = IDLE_MAX;
      run_motion(200);
   endtask

   initial begin
      // predicted reset state
      dist_per_count = ecse_pkg::DPC_RESET;
      enc_count      = '0;
      est_count      = '0;
      evt_stamp      = '0;
      est_stamp      = '0;
      held_speed     = '0;
      stale_level    = 4'd1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_estimate_and_decay();
      test_wrap_and_saturation();
      test_distance_settings();
      test_backpressure();

      wait_idle();
      if (fail_count == 0)
         $display("** encoder_count_speed_estimator: PASSED **");
      else
         $display("** encoder_count_speed_estimator: FAILED **");
      $finish;
   end

endmodule

[files.f]
src/ecse_pkg.sv
src/ecse_fifo.sv
src/ecse_front.sv
src/ecse_back.sv
src/encoder_count_speed_estimator.sv
src/ecse_checker.sv
test/tb_encoder_count_speed_estimator.sv
